>>> rtl/triangle_layer_slicer_unit_assert.svh
// ----------------------------------------------------------------------------
// triangle layer slicer assertion macros
// clocked check shorthand used by tls_dp
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_LAYER_SLICER_UNIT_ASSERT_SVH
`define TRIANGLE_LAYER_SLICER_UNIT_ASSERT_SVH

// labeled concurrent check
`define TLS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// labeled check that a condition never holds
`define TLS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// shared types, constants and codes of the triangle layer slicer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tls_pkg;

  localparam int LAYERS   = 4096;
  localparam int LAYER_W  = $clog2(LAYERS);
  localparam int LN_W     = 12;
  localparam int MAX_SEGS = 64;
  localparam int SEG_W    = $clog2(MAX_SEGS + 1);
  localparam int H_W      = 20;
  localparam int Z_W      = 31;
  localparam int C_W      = 32;
  localparam int DVD_W    = Z_W + C_W;
  localparam logic [H_W-1:0] H_RESET = 20'd19661;

  localparam logic [2:0] SEL_FIRST = 3'd0;
  localparam logic [2:0] SEL_MID   = 3'd1;
  localparam logic [2:0] SEL_END   = 3'd2;
  localparam logic [2:0] SEL_LX    = 3'd3;
  localparam logic [2:0] SEL_LY    = 3'd4;
  localparam logic [2:0] SEL_SX    = 3'd5;
  localparam logic [2:0] SEL_SY    = 3'd6;

  typedef struct packed {
    logic signed [C_W-1:0] ax;
    logic signed [C_W-1:0] ay;
    logic        [Z_W-1:0] az;
    logic signed [C_W-1:0] bx;
    logic signed [C_W-1:0] by_coord;
    logic        [Z_W-1:0] bz;
    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] cy;
    logic        [Z_W-1:0] cz;
  } tri_in_t;

  typedef struct packed {
    logic        [LN_W-1:0] layer_number;
    logic signed [C_W-1:0]  long_edge_x;
    logic signed [C_W-1:0]  long_edge_y;
    logic signed [C_W-1:0]  short_edge_x;
    logic signed [C_W-1:0]  short_edge_y;
    logic                   last_segment;
    logic                   truncated;
  } seg_out_t;

  typedef struct packed {
    logic signed [C_W-1:0] x;
    logic signed [C_W-1:0] y;
    logic        [Z_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic       load_tri;
    logic       div_start;
    logic       div_cap;
    logic       zc_load;
    logic       num_load;
    logic       mul_load;
    logic       layer_inc;
    logic       out_load;
    logic [2:0] sel;
  } tls_cmd_t;

  typedef struct packed {
    logic div_done;
    logic h_zero;
    logic layer_done;
    logic layer_valid;
    logic emit_last;
    logic out_free;
  } tls_sts_t;

endpackage

`default_nettype wire

>>> rtl/triangle_layer_slicer_unit.sv
// ----------------------------------------------------------------------------
// triangle_layer_slicer_unit
// cuts one triangle with horizontal slice planes, at most one segment per layer
//
//   port group  direction  flow control   payload
//   in_         request    valid / stall  tri_in_t, three vertices
//   out_        result     valid / stall  seg_out_t, one segment
//   cfg_        write      valid / ready  layer height, 20 bit
//
// setup runs three layer-bound divisions, one after another
// each emitted segment runs edge divisions for long x, long y, short x and short y, plus steps
// a layer with a flat edge is skipped without a division; the divider sets the pace
// a request is taken only while the sequencer is idle; a held result waits
// in the output register and stalls only the emit step
// synchronous active-low reset restores the layer height to 0.3 mm
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_layer_slicer_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire tls_pkg::tri_in_t        in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output tls_pkg::seg_out_t            out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [tls_pkg::H_W-1:0] cfg_data
);
  import tls_pkg::*;

  tls_cmd_t cmd;
  tls_sts_t sts;

  assign cfg_ready = 1'b1;

  tls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/tls_div.sv
// ----------------------------------------------------------------------------
// tls_div
// restoring divider, one quotient bit per cycle, 32-bit quotient
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tls_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tls_pkg::DVD_W-1:0] dividend,
  input  wire logic [tls_pkg::Z_W-1:0]   divisor,
  output logic      [tls_pkg::C_W-1:0]   quot,
  output logic                           busy,
  output logic                           done
);
  import tls_pkg::*;

  localparam int CNT_W = $clog2(C_W);

  logic [Z_W-1:0]   rem_r;
  logic [C_W-1:0]   low_r;
  logic [Z_W-1:0]   div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [Z_W:0]     trial;
  logic [Z_W:0]     diff;
  logic             ge;

  assign trial = {rem_r, low_r[C_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DVD_W-1:C_W];
      low_r <= dividend[C_W-1:0];
      div_r <= divisor;
      cnt_r <= CNT_W'(C_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? diff[Z_W-1:0] : trial[Z_W-1:0];
      low_r <= {low_r[C_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quot = low_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

>>> rtl/tls_dp.sv
// ----------------------------------------------------------------------------
// tls_dp
// datapath: vertex sort, layer bounds, edge interpolation, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tls_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tls_pkg::tri_in_t        in_data,
  input  wire logic                    cfg_we,
  input  wire logic [tls_pkg::H_W-1:0] cfg_data,
  input  wire tls_pkg::tls_cmd_t       cmd,
  output tls_pkg::tls_sts_t            sts,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output tls_pkg::seg_out_t            out_data
);
  import tls_pkg::*;

  function automatic logic [Z_W-1:0] cut_num(input logic [C_W-1:0] zc,
                                             input logic [Z_W-1:0] loz,
                                             input logic [Z_W-1:0] hiz);
    logic [Z_W-1:0] span;
    logic [C_W-1:0] rise;
    span = hiz - loz;
    rise = (zc > {1'b0, loz}) ? zc - {1'b0, loz} : '0;
    cut_num = (rise > {1'b0, span}) ? span : rise[Z_W-1:0];
  endfunction

  vtx_t va, vb, vc, s_mx, s_mn, s_md;
  vtx_t mn_r, md_r, mx_r;
  logic [H_W-1:0]     h_r;
  logic [C_W-1:0]     first_r, mid_r, layer_r, zc_r;
  logic [LAYER_W:0]   end_r;
  logic [SEG_W-1:0]   seg_cnt_r;
  logic [Z_W-1:0]     num_l_r, num_s_r, den_r;
  logic               s_up_r, neg_r;
  logic [DVD_W-1:0]   prod_r;
  logic [C_W-1:0]     lo_c_r, lx_r, ly_r, sx_r, sy_r;
  logic               out_valid_r;
  seg_out_t           out_data_r;

  logic               flat, low_ok, high_ok, lt_mid, layer_valid, layer_done;
  logic [C_W:0]       nxt_j, jm;
  logic               next_exists, at_cap, emit_last;
  vtx_t               lo_v, hi_v;
  logic               is_long, is_y;
  logic [C_W-1:0]     lo_c, hi_c, mag;
  logic [C_W:0]       cdiff;
  logic [Z_W-1:0]     num_sel;
  logic [C_W-1:0]     hm1, zsum;
  logic [DVD_W-1:0]   dvd;
  logic [Z_W-1:0]     dvs;
  logic [C_W-1:0]     quot, res;
  logic               div_busy, div_done;
  logic               out_free;

  // z ordering of the three vertices
  always_comb begin
    va = '{x: in_data.ax, y: in_data.ay, z: in_data.az};
    vb = '{x: in_data.bx, y: in_data.by_coord, z: in_data.bz};
    vc = '{x: in_data.cx, y: in_data.cy, z: in_data.cz};
    s_mx = va;
    s_mn = va;
    s_md = va;
    if (vb.z > s_mx.z) begin
      s_mx = vb;
    end else begin
      s_mn = vb;
    end
    if (vc.z > s_mx.z) begin
      s_md = s_mx;
      s_mx = vc;
    end else if (vc.z < s_mn.z) begin
      s_md = s_mn;
      s_mn = vc;
    end else begin
      s_md = vc;
    end
  end

  // layer classification and lookahead
  always_comb begin
    flat        = mx_r.z == mn_r.z;
    low_ok      = md_r.z != mn_r.z;
    high_ok     = mx_r.z != md_r.z;
    lt_mid      = layer_r < mid_r;
    layer_done  = layer_r >= C_W'(end_r);
    layer_valid = !flat && (lt_mid ? low_ok : high_ok);
    nxt_j       = {1'b0, layer_r} + 1'b1;
    jm          = (nxt_j > {1'b0, mid_r}) ? nxt_j : {1'b0, mid_r};
    next_exists = !flat &&
                  ((low_ok && nxt_j < {1'b0, mid_r} && nxt_j < (C_W + 1)'(end_r)) ||
                   (high_ok && jm < (C_W + 1)'(end_r)));
    at_cap      = seg_cnt_r == SEG_W'(MAX_SEGS - 1);
    emit_last   = !next_exists || at_cap;
  end

  // edge and coordinate for the current interpolation
  always_comb begin
    is_long = cmd.sel == SEL_LX || cmd.sel == SEL_LY;
    is_y    = cmd.sel == SEL_LY || cmd.sel == SEL_SY;
    if (is_long) begin
      lo_v = mn_r;
      hi_v = mx_r;
    end else if (s_up_r) begin
      lo_v = md_r;
      hi_v = mx_r;
    end else begin
      lo_v = mn_r;
      hi_v = md_r;
    end
    lo_c    = is_y ? lo_v.y : lo_v.x;
    hi_c    = is_y ? hi_v.y : hi_v.x;
    cdiff   = {hi_c[C_W-1], hi_c} - {lo_c[C_W-1], lo_c};
    mag     = cdiff[C_W] ? C_W'(-cdiff) : cdiff[C_W-1:0];
    num_sel = is_long ? num_l_r : num_s_r;
  end

  // divider operands
  always_comb begin
    hm1  = C_W'(h_r) - 1'b1;
    zsum = '0;
    dvd  = prod_r;
    dvs  = den_r;
    case (cmd.sel)
      SEL_FIRST: begin
        zsum = {1'b0, mn_r.z} + hm1;
        dvd  = DVD_W'(zsum);
        dvs  = Z_W'(h_r);
      end
      SEL_MID: begin
        zsum = {1'b0, md_r.z} + hm1;
        dvd  = DVD_W'(zsum);
        dvs  = Z_W'(h_r);
      end
      SEL_END: begin
        dvd = DVD_W'(mx_r.z);
        dvs = Z_W'(h_r);
      end
      default: begin
        dvd = prod_r;
        dvs = den_r;
      end
    endcase
  end

  tls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (quot),
    .busy     (div_busy),
    .done     (div_done)
  );

  assign res = neg_r ? lo_c_r - quot : lo_c_r + quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r       <= H_RESET;
      seg_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        h_r <= cfg_data;
      end
      if (cmd.load_tri) begin
        seg_cnt_r <= '0;
      end else if (cmd.out_load) begin
        seg_cnt_r <= seg_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tri) begin
      mn_r <= s_mn;
      md_r <= s_md;
      mx_r <= s_mx;
    end
    if (cmd.zc_load) begin
      zc_r <= C_W'(layer_r[LAYER_W-1:0]) * C_W'(h_r);
    end
    if (cmd.num_load) begin
      num_l_r <= cut_num(zc_r, mn_r.z, mx_r.z);
      num_s_r <= lt_mid ? cut_num(zc_r, mn_r.z, md_r.z) : cut_num(zc_r, md_r.z, mx_r.z);
      s_up_r  <= !lt_mid;
    end
    if (cmd.mul_load) begin
      prod_r <= {{C_W{1'b0}}, num_sel} * {{Z_W{1'b0}}, mag};
      den_r  <= hi_v.z - lo_v.z;
      neg_r  <= cdiff[C_W];
      lo_c_r <= lo_c;
    end
    if (cmd.layer_inc) begin
      layer_r <= layer_r + 1'b1;
    end
    if (cmd.div_cap) begin
      case (cmd.sel)
        SEL_FIRST: first_r <= quot;
        SEL_MID:   mid_r   <= quot;
        SEL_END: begin
          end_r   <= (quot >= C_W'(LAYERS)) ? (LAYER_W + 1)'(LAYERS)
                                            : quot[LAYER_W:0] + 1'b1;
          layer_r <= first_r;
        end
        SEL_LX:  lx_r <= res;
        SEL_LY:  ly_r <= res;
        SEL_SX:  sx_r <= res;
        SEL_SY:  sy_r <= res;
        default: lx_r <= lx_r;
      endcase
    end
  end

  // result register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.layer_number <= layer_r[LN_W-1:0];
      out_data_r.long_edge_x  <= lx_r;
      out_data_r.long_edge_y  <= ly_r;
      out_data_r.short_edge_x <= sx_r;
      out_data_r.short_edge_y <= sy_r;
      out_data_r.last_segment <= emit_last;
      out_data_r.truncated    <= at_cap && next_exists;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.div_done    = div_done;
    sts.h_zero      = h_r == '0;
    sts.layer_done  = layer_done;
    sts.layer_valid = layer_valid;
    sts.emit_last   = emit_last;
    sts.out_free    = out_free;
  end

`include "triangle_layer_slicer_unit_assert.svh"

  `TLS_CHECK(a_div_start_idle, cmd.div_start |-> !div_busy, "divider restarted while busy")
  `TLS_NEVER(a_seg_cap, seg_cnt_r > SEG_W'(MAX_SEGS), "segment count past cap")
  `TLS_CHECK(a_out_load_free, cmd.out_load |-> out_free, "result register overwritten")

endmodule

`default_nettype wire

>>> rtl/tls_ctrl.sv
// ----------------------------------------------------------------------------
// tls_ctrl
// sequencer: layer bounds, per-layer interpolation steps, segment emit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tls_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tls_pkg::tls_sts_t sts,
  output tls_pkg::tls_cmd_t      cmd
);
  import tls_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DWAIT  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_NUM    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_FIRST;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_tri = 1'b1;
          if (!sts.h_zero) begin
            sel_nxt   = SEL_FIRST;
            state_nxt = S_DSTART;
          end
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          case (sel_r)
            SEL_FIRST: begin
              sel_nxt   = SEL_MID;
              state_nxt = S_DSTART;
            end
            SEL_MID: begin
              sel_nxt   = SEL_END;
              state_nxt = S_DSTART;
            end
            SEL_END: state_nxt = S_CHECK;
            SEL_LX: begin
              sel_nxt   = SEL_LY;
              state_nxt = S_MUL;
            end
            SEL_LY: begin
              sel_nxt   = SEL_SX;
              state_nxt = S_MUL;
            end
            SEL_SX: begin
              sel_nxt   = SEL_SY;
              state_nxt = S_MUL;
            end
            SEL_SY:  state_nxt = S_EMIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (sts.layer_done) begin
          state_nxt = S_IDLE;
        end else if (sts.layer_valid) begin
          cmd.zc_load = 1'b1;
          state_nxt   = S_NUM;
        end else begin
          cmd.layer_inc = 1'b1;
        end
      end
      S_NUM: begin
        cmd.num_load = 1'b1;
        sel_nxt      = SEL_LX;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DSTART;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.layer_inc = 1'b1;
          state_nxt     = sts.emit_last ? S_IDLE : S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
